// ----- src/tssms_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tssms_pkg
// Shared types, codes and constants of the two-speed stepper move sequencer.
// ----------------------------------------------------------------------------
package tssms_pkg;

    // Default width of the tracked position
    localparam int POSITION_BITS_DEFAULT = 32;

    // Register port geometry
    localparam int APB_ADDR_BITS = 5;
    localparam int APB_DATA_BITS = 32;

    // Register reset values
    localparam logic [15:0] FAST_THRESHOLD_RESET = 16'd1000;
    localparam logic [15:0] SLOW_STEPS_RESET     = 16'd100;
    localparam logic [7:0]  DEFAULT_SPEED        = 8'd10;

    // Command codes of an input transaction
    typedef enum logic [1:0] {
        FUNC_MOVE  = 2'd0,
        FUNC_SET   = 2'd1,
        FUNC_TICK  = 2'd2,
        FUNC_ABORT = 2'd3
    } func_t;

    // Register indexes (word address)
    typedef enum logic [2:0] {
        REG_FAST_THRESHOLD    = 3'd0,
        REG_SLOW_STEPS        = 3'd1,
        REG_FAST_SPEED        = 3'd2,
        REG_SLOW_SPEED        = 3'd3,
        REG_DIRECTION_SWAPPED = 3'd4
    } reg_idx_t;

    // Configuration as seen by the sequencer
    typedef struct packed {
        logic [15:0] fast_threshold;
        logic [15:0] slow_steps;
        logic [7:0]  fast_speed;
        logic [7:0]  slow_speed;
        logic        direction_swapped;
    } cfg_t;

    // One result transaction
    typedef struct packed {
        logic        step_valid;
        logic        step_forward;
        logic        step_fine;
        logic [7:0]  speed_rpm;
        logic [31:0] current_position;
        logic        busy_res;
        logic        move_done;
    } result_t;

    // A speed setting of zero reports as one
    function automatic logic [7:0] speed_of(input logic [7:0] s);
        speed_of = (s == 8'd0) ? 8'd1 : s;
    endfunction

endpackage

// ----- src/two_speed_stepper_move_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_speed_stepper_move_sequencer
// Stepper move sequencer with a fast full-step phase and a slow microstep
// phase, driven by move, set-position, tick and abort commands.
// ----------------------------------------------------------------------------
// Every input transaction (move, set position, tick, abort) gives exactly one
// result transaction. The block takes one transaction per clock cycle while
// in_stall is low. The command and its clamped value are held in an input
// register. Once the result register is free, the sequencer updates position
// and phase counters in a single step into the result register. A stalled
// result holds the input register; an empty input register still takes one
// more command, and further commands are then stalled until the result is taken.
// A tick issues at most one step, reported with direction, full or micro step
// mode and speed; move_done marks the end of a move (release the coils).
// The user writes configuration registers through the APB-style port only while
// no transaction is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module two_speed_stepper_move_sequencer
#(
    parameter int POSITION_BITS = tssms_pkg::POSITION_BITS_DEFAULT
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [tssms_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [tssms_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [tssms_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                 pready,
    // command channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [1:0]                           func,
    input  logic signed [31:0]                   value,
    // result channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 step_valid,
    output logic                                 step_forward,
    output logic                                 step_fine,
    output logic [7:0]                           speed_rpm,
    output logic signed [31:0]                   current_position,
    output logic                                 busy_res,
    output logic                                 move_done
);

    localparam int EXT_BITS = (POSITION_BITS > 32) ? POSITION_BITS : 32;
    localparam logic signed [EXT_BITS-1:0] POS_MAX_EXT =
        EXT_BITS'({1'b0, {(POSITION_BITS-1){1'b1}}});
    localparam logic signed [EXT_BITS-1:0] POS_MIN_EXT = ~POS_MAX_EXT;

    tssms_pkg::cfg_t                 cfg;
    tssms_pkg::result_t              res_next;
    tssms_pkg::result_t              res_reg;

    logic                            s1_valid_reg;
    tssms_pkg::func_t                s1_func_reg;
    logic signed [POSITION_BITS-1:0] s1_tgt_reg;
    logic                            out_valid_reg;

    logic signed [EXT_BITS-1:0]      val_ext;
    logic signed [EXT_BITS-1:0]      val_clamped;
    logic                            out_free;
    logic                            advance;
    logic                            in_take;

    // Configuration registers
    tssms_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Clamp the value into the position range
    assign val_ext = EXT_BITS'(value);
    always_comb
    begin
        priority if (val_ext > POS_MAX_EXT)
            val_clamped = POS_MAX_EXT;
        else if (val_ext < POS_MIN_EXT)
            val_clamped = POS_MIN_EXT;
        else
            val_clamped = val_ext;
    end

    // Handshake: the input register doubles as the skid stage
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    // Hold the accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_func_reg <= tssms_pkg::func_t'(func);
            s1_tgt_reg  <= POSITION_BITS'(val_clamped);
        end
    end

    // Sequencer state and step decision
    tssms_seq #(
        .POSITION_BITS (POSITION_BITS)
    ) u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .func   (s1_func_reg),
        .target (s1_tgt_reg),
        .cfg    (cfg),
        .result (res_next)
    );

    // Result register: load on advance, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    // Drive the result channel
    assign out_valid        = out_valid_reg;
    assign step_valid       = res_reg.step_valid;
    assign step_forward     = res_reg.step_forward;
    assign step_fine        = res_reg.step_fine;
    assign speed_rpm        = res_reg.speed_rpm;
    assign current_position = res_reg.current_position;
    assign busy_res         = res_reg.busy_res;
    assign move_done        = res_reg.move_done;

endmodule

// ----- src/tssms_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tssms_regs
// Configuration registers behind an APB-style port, one register per word.
// ----------------------------------------------------------------------------
module tssms_regs
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [tssms_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [tssms_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [tssms_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                 pready,
    output tssms_pkg::cfg_t                      cfg
);

    tssms_pkg::cfg_t     cfg_reg;
    tssms_pkg::reg_idx_t idx;
    logic                wr_en;

    assign idx    = tssms_pkg::reg_idx_t'(paddr[tssms_pkg::APB_ADDR_BITS-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Write the addressed register on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fast_threshold    <= tssms_pkg::FAST_THRESHOLD_RESET;
            cfg_reg.slow_steps        <= tssms_pkg::SLOW_STEPS_RESET;
            cfg_reg.fast_speed        <= tssms_pkg::DEFAULT_SPEED;
            cfg_reg.slow_speed        <= tssms_pkg::DEFAULT_SPEED;
            cfg_reg.direction_swapped <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                tssms_pkg::REG_FAST_THRESHOLD:    cfg_reg.fast_threshold    <= pwdata[15:0];
                tssms_pkg::REG_SLOW_STEPS:        cfg_reg.slow_steps        <= pwdata[15:0];
                tssms_pkg::REG_FAST_SPEED:        cfg_reg.fast_speed        <= pwdata[7:0];
                tssms_pkg::REG_SLOW_SPEED:        cfg_reg.slow_speed        <= pwdata[7:0];
                tssms_pkg::REG_DIRECTION_SWAPPED: cfg_reg.direction_swapped <= pwdata[0];
                default:
                begin
                end
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        unique case (idx)
            tssms_pkg::REG_FAST_THRESHOLD:    prdata = 32'(cfg_reg.fast_threshold);
            tssms_pkg::REG_SLOW_STEPS:        prdata = 32'(cfg_reg.slow_steps);
            tssms_pkg::REG_FAST_SPEED:        prdata = 32'(cfg_reg.fast_speed);
            tssms_pkg::REG_SLOW_SPEED:        prdata = 32'(cfg_reg.slow_speed);
            tssms_pkg::REG_DIRECTION_SWAPPED: prdata = 32'(cfg_reg.direction_swapped);
            default:                          prdata = '0;
        endcase
    end

endmodule

// ----- src/tssms_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tssms_seq
// Move state and step decision: position, phase counters, direction, active.
// ----------------------------------------------------------------------------
module tssms_seq
#(
    parameter int POSITION_BITS = tssms_pkg::POSITION_BITS_DEFAULT
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            fire,
    input  tssms_pkg::func_t                func,
    input  logic signed [POSITION_BITS-1:0] target,
    input  tssms_pkg::cfg_t                 cfg,
    output tssms_pkg::result_t              result
);

    localparam logic signed [POSITION_BITS-1:0] POS_MAX = {1'b0, {(POSITION_BITS-1){1'b1}}};
    localparam logic signed [POSITION_BITS-1:0] POS_MIN = {1'b1, {(POSITION_BITS-1){1'b0}}};

    logic signed [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0]        fast_left_reg, fast_left_next;
    logic [POSITION_BITS-1:0]        slow_left_reg, slow_left_next;
    logic                            up_reg, up_next;
    logic                            active_reg, active_next;

    logic                            tgt_up;
    logic [POSITION_BITS-1:0]        mag;
    logic [POSITION_BITS-1:0]        thr_ext;
    logic [POSITION_BITS-1:0]        slow_ext;
    logic                            blocked;

    // Distance to the target and phase limits
    assign tgt_up   = target > pos_reg;
    assign mag      = tgt_up ? POSITION_BITS'(target - pos_reg)
                             : POSITION_BITS'(pos_reg - target);
    assign thr_ext  = POSITION_BITS'(cfg.fast_threshold);
    assign slow_ext = POSITION_BITS'(cfg.slow_steps);
    assign blocked  = up_reg ? (pos_reg == POS_MAX)
                             : ((pos_reg == '0) || (pos_reg == POS_MIN));

    // Decide the step and the next move state
    always_comb
    begin
        pos_next              = pos_reg;
        fast_left_next        = fast_left_reg;
        slow_left_next        = slow_left_reg;
        up_next               = up_reg;
        active_next           = active_reg;
        result.step_valid     = 1'b0;
        result.step_forward   = 1'b0;
        result.step_fine      = 1'b0;
        result.speed_rpm      = tssms_pkg::speed_of(cfg.slow_speed);
        result.move_done      = 1'b0;

        unique case (func)
            tssms_pkg::FUNC_MOVE:
            begin
                up_next = tgt_up;
                if (mag == '0)
                begin
                    active_next      = 1'b0;
                    fast_left_next   = '0;
                    slow_left_next   = '0;
                    result.move_done = 1'b1;
                end
                else
                begin
                    // Long move: fast phase first, last slow_steps done fine
                    if ((mag > thr_ext) && (slow_ext < mag))
                    begin
                        fast_left_next = mag - slow_ext;
                        slow_left_next = slow_ext;
                    end
                    else
                    begin
                        fast_left_next = '0;
                        slow_left_next = mag;
                    end
                    active_next = 1'b1;
                end
            end
            tssms_pkg::FUNC_SET:
            begin
                if (active_reg)
                begin
                    active_next      = 1'b0;
                    fast_left_next   = '0;
                    slow_left_next   = '0;
                    result.move_done = 1'b1;
                end
                pos_next = target;
            end
            tssms_pkg::FUNC_TICK:
            begin
                if (active_reg)
                begin
                    if (blocked)
                    begin
                        active_next      = 1'b0;
                        fast_left_next   = '0;
                        slow_left_next   = '0;
                        result.move_done = 1'b1;
                    end
                    else
                    begin
                        result.step_valid   = 1'b1;
                        result.step_forward = up_reg ? cfg.direction_swapped
                                                     : !cfg.direction_swapped;
                        if (fast_left_reg != '0)
                        begin
                            result.step_fine = 1'b0;
                            result.speed_rpm = tssms_pkg::speed_of(cfg.fast_speed);
                            fast_left_next   = fast_left_reg - 1'b1;
                        end
                        else
                        begin
                            result.step_fine = 1'b1;
                            slow_left_next   = slow_left_reg - 1'b1;
                        end
                        pos_next = up_reg ? pos_reg + 1'b1 : pos_reg - 1'b1;
                        if ((fast_left_next == '0) && (slow_left_next == '0))
                        begin
                            active_next      = 1'b0;
                            result.move_done = 1'b1;
                        end
                    end
                end
            end
            tssms_pkg::FUNC_ABORT:
            begin
                if (active_reg)
                begin
                    active_next      = 1'b0;
                    fast_left_next   = '0;
                    slow_left_next   = '0;
                    result.move_done = 1'b1;
                end
            end
        endcase

        result.current_position = 32'(pos_next);
        result.busy_res         = active_next;
    end

    // Advance the move state once per processed transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            fast_left_reg <= '0;
            slow_left_reg <= '0;
            up_reg        <= 1'b0;
            active_reg    <= 1'b0;
        end
        else if (fire)
        begin
            pos_reg       <= pos_next;
            fast_left_reg <= fast_left_next;
            slow_left_reg <= slow_left_next;
            up_reg        <= up_next;
            active_reg    <= active_next;
        end
    end

endmodule
